[design/sgs_pkg.sv]
package sgs_pkg;

  // largest sequence length supported; the step counter is four bits wide
  localparam int MaxSteps  = 16;
  localparam int StepLimit = (MaxSteps < 16) ? MaxSteps : 16;

  localparam logic [15:0] PulseTicksRst = 16'd48;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgClockExternal = 2'd0,
    CfgGateMode      = 2'd1,
    CfgPulseTicks    = 2'd2
  } cfg_index_e;

  // gate output modes
  typedef enum logic [1:0] {
    GateTrigger    = 2'd0,
    GateRetrigger  = 2'd1,
    GateContinuous = 2'd2
  } gate_mode_e;

  // one input word as held in the input register
  typedef struct packed {
    logic        run_level;
    logic        reset_level;
    logic        ext_clock_level;
    logic [31:0] phase_increment;
    logic [4:0]  step_count;
    logic        note_in;
    logic        clear_in;
    logic [15:0] gate_button_levels;
    logic [15:0] gate_cv_levels;
  } in_word_t;

endpackage

[design/step_gate_sequencer_unit.sv]
// Sixteen-step gate sequencer, one input word per sample tick.
// Input channel: in_valid_i / in_ready_o with the button, clock and gate levels,
// the phase increment and the step count of one tick.
// Output channel: out_valid_o / out_ready_i with gate_out_o, running_flag_o,
// current_step_o and gate_pattern_o for that tick, one output word per input word.
// Configuration channel: cfg_valid_i / cfg_ready_o, always ready; cfg_index_i
// selects clock_external (0), gate_mode (1) or pulse_ticks (2), other indexes
// are ignored. Write it only while no word is in flight.
// A word accepted into the input register is evaluated against the sequencer
// state when it moves on to the output registers; while an untaken output word
// holds the output registers, the word waits in the input register.
// Throughput: one word per cycle while output words are taken; input and output
// registers form a two-entry pipeline, so a word is taken while a result waits.
// When the receiver stalls, the output word holds, the input register fills and
// in_ready_o drops until the output word is taken.
// Reset: sequencer running at step 0, all gates clear, no pulse, all edge
// detectors at low, pulse_ticks 48, internal clock, trigger mode.
module step_gate_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        run_level_i,
  input  logic        reset_level_i,
  input  logic        ext_clock_level_i,
  input  logic [31:0] phase_increment_i,
  input  logic [4:0]  step_count_i,
  input  logic        note_in_i,
  input  logic        clear_in_i,
  input  logic [15:0] gate_button_levels_i,
  input  logic [15:0] gate_cv_levels_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        gate_out_o,
  output logic        running_flag_o,
  output logic [3:0]  current_step_o,
  output logic [15:0] gate_pattern_o,
  // configuration channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import sgs_pkg::*;

  localparam logic [4:0] StepLimitW = 5'(StepLimit);

  // configuration registers
  logic        clock_external_q;
  logic [1:0]  gate_mode_q;
  logic [15:0] pulse_ticks_q;

  // pipeline control and payload
  logic        in_vld_q;
  in_word_t    in_q;
  logic        out_vld_q;
  logic        gate_q;
  logic        running_out_q;
  logic [3:0]  step_out_q;
  logic [15:0] pattern_out_q;
  logic        fire;

  // sequencer state
  logic        running_q, running_d;
  logic [31:0] phase_q, phase_d;
  logic [3:0]  step_q, step_d;
  logic [15:0] gates_q, gates_d;
  logic [15:0] remain_q, remain_d;
  logic        prev_run_q, prev_rst_q, prev_ext_q, prev_ext_d;
  logic [15:0] prev_btn_q, prev_cv_q;
  logic        gate_d;

  // handshakes
  assign fire        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || fire;
  assign cfg_ready_o = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_external_q <= 1'b0;
      gate_mode_q      <= GateTrigger;
      pulse_ticks_q    <= PulseTicksRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CfgClockExternal: clock_external_q <= cfg_data_i[0];
        CfgGateMode:      gate_mode_q      <= cfg_data_i[1:0];
        CfgPulseTicks:    pulse_ticks_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= '{run_level:          run_level_i,
                reset_level:        reset_level_i,
                ext_clock_level:    ext_clock_level_i,
                phase_increment:    phase_increment_i,
                step_count:         step_count_i,
                note_in:            note_in_i,
                clear_in:           clear_in_i,
                gate_button_levels: gate_button_levels_i,
                gate_cv_levels:     gate_cv_levels_i};
    end
  end

  // one tick of the sequencer
  always_comb begin
    logic        advance;
    logic        rst_edge;
    logic [32:0] sum;
    logic [4:0]  count;
    logic [4:0]  base;
    logic [4:0]  next;
    logic [15:0] rem_adv;
    logic        pulse;
    logic        gate_bit;

    // run edge toggles the run flag
    running_d = running_q ^ (in_q.run_level && !prev_run_q);

    // clock source, only while running
    advance    = 1'b0;
    phase_d    = phase_q;
    prev_ext_d = prev_ext_q;
    sum        = {1'b0, phase_q} + {1'b0, in_q.phase_increment};
    if (running_d) begin
      if (clock_external_q) begin
        if (in_q.ext_clock_level && !prev_ext_q) begin
          phase_d = '0;
          advance = 1'b1;
        end
        prev_ext_d = in_q.ext_clock_level;
      end else begin
        phase_d = sum[31:0];
        advance = sum[32];
      end
    end

    // reset edge lands the advance on step 0
    rst_edge = in_q.reset_level && !prev_rst_q;
    base     = {1'b0, step_q};
    if (rst_edge) begin
      phase_d = '0;
      base    = StepLimitW;
      advance = 1'b1;
    end

    // advance with wrap at the clamped count
    count = in_q.step_count;
    if (count == 5'd0) count = 5'd1;
    if (count > StepLimitW) count = StepLimitW;
    next = base + 5'd1;
    if (next >= count) next = 5'd0;

    step_d  = step_q;
    gates_d = gates_q;
    rem_adv = remain_q;
    if (advance) begin
      step_d = next[3:0];
      if (in_q.note_in) gates_d[next[3:0]] = 1'b1;
      if (in_q.clear_in) gates_d[next[3:0]] = 1'b0;
      if (pulse_ticks_q > remain_q) rem_adv = pulse_ticks_q;
    end

    // pulse countdown
    pulse    = (rem_adv != 16'd0);
    remain_d = rem_adv - {15'd0, pulse};

    // gate toggles from buttons and gate inputs
    gates_d = gates_d ^ ((in_q.gate_cv_levels & ~prev_cv_q)
                       ^ (in_q.gate_button_levels & ~prev_btn_q));

    // output gate by mode
    gate_bit = running_d && gates_d[step_d];
    case (gate_mode_e'(gate_mode_q))
      GateTrigger:   gate_d = gate_bit && pulse;
      GateRetrigger: gate_d = gate_bit && !pulse;
      default:       gate_d = gate_bit;
    endcase
  end

  // state update, one per processed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q  <= 1'b1;
      phase_q    <= '0;
      step_q     <= '0;
      gates_q    <= '0;
      remain_q   <= '0;
      prev_run_q <= 1'b0;
      prev_rst_q <= 1'b0;
      prev_ext_q <= 1'b0;
      prev_btn_q <= '0;
      prev_cv_q  <= '0;
    end else if (fire) begin
      running_q  <= running_d;
      phase_q    <= phase_d;
      step_q     <= step_d;
      gates_q    <= gates_d;
      remain_q   <= remain_d;
      prev_run_q <= in_q.run_level;
      prev_rst_q <= in_q.reset_level;
      prev_ext_q <= prev_ext_d;
      prev_btn_q <= in_q.gate_button_levels;
      prev_cv_q  <= in_q.gate_cv_levels;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      gate_q        <= gate_d;
      running_out_q <= running_d;
      step_out_q    <= step_d;
      pattern_out_q <= gates_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign gate_out_o     = gate_q;
  assign running_flag_o = running_out_q;
  assign current_step_o = step_out_q;
  assign gate_pattern_o = pattern_out_q;

`ifndef SYNTHESIS
  // the step never reaches the step limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, current_step_o} < StepLimitW))
    else $error("current step beyond step limit");

  // a high gate needs the sequencer running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && gate_out_o) |-> running_flag_o)
    else $error("gate high while stopped");

  // a high gate needs the stored bit of the current step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && gate_out_o) |-> gate_pattern_o[current_step_o])
    else $error("gate high on a cleared step");

  // input side only stalls with both registers full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && out_vld_q && !out_ready_i))
    else $error("input stalled without backpressure");
`endif

endmodule
